// ----- hw/rtl/tcw_pkg.sv -----
// tcw_pkg: command codes, character constants and the memory control word
// shared by the text console writer modules. No dependencies.
package tcw_pkg;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_BACK  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] NULL_CHAR    = 8'h00;

	// Screen memory request issued for one accepted word.
	typedef struct packed {
		logic wr;     // write wr_data at wr_addr
		logic rd;     // read rd_addr into the read register
		logic clr;    // start a blanking sweep over every cell
	} mem_ctl_t;

endpackage

// ----- hw/rtl/tcw_cursor.sv -----
// tcw_cursor: cursor registers and command decode for the text console writer.
// Produces the next cursor and the screen memory request. Depends on tcw_pkg.
module tcw_cursor import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  cmd_t                                  cmd,
	input  logic [7:0]                            char_code,
	input  logic [10:0]                           cell_index,
	output mem_ctl_t                              ctl,
	output logic [$clog2(COLUMNS*ROWS)-1:0]       wr_addr,
	output logic [7:0]                            wr_data,
	output logic [$clog2(COLUMNS*ROWS)-1:0]       rd_addr,
	output logic [$clog2(COLUMNS)-1:0]            col_next,
	output logic [$clog2(ROWS)-1:0]               row_next
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CELL_W-1:0] row_base;
	logic              in_range;
	mem_ctl_t          ctl_raw;

	assign row_base = CELL_W'(row_q) * CELL_W'(COLUMNS);
	assign in_range = (32'(cell_index) < 32'(CELL_COUNT));
	assign rd_addr  = CELL_W'(cell_index);

	always_comb begin
		col_next = col_q;
		row_next = row_q;
		ctl_raw  = '0;
		wr_addr  = row_base + CELL_W'(col_q);
		wr_data  = char_code;
		unique case (cmd)
			CMD_PUT: begin
				if (char_code != NULL_CHAR) begin
					if (char_code == NEWLINE_CHAR) begin
						col_next = '0;
						if (row_q == ROW_LAST) ctl_raw.clr = 1'b1;
						else row_next = row_q + ROW_W'(1);
					end else begin
						ctl_raw.wr = 1'b1;
						if (col_q == COL_LAST) begin
							col_next = '0;
							if (row_q == ROW_LAST) ctl_raw.clr = 1'b1;
							else row_next = row_q + ROW_W'(1);
						end else begin
							col_next = col_q + COL_W'(1);
						end
					end
				end
			end
			CMD_BACK: begin
				if (col_q != '0) begin
					col_next   = col_q - COL_W'(1);
					ctl_raw.wr = 1'b1;
					wr_addr    = row_base + CELL_W'(col_q - COL_W'(1));
					wr_data    = BLANK_CHAR;
				end
			end
			CMD_CLEAR: ctl_raw.clr = 1'b1;
			CMD_READ:  ctl_raw.rd  = in_range;
			default:   ctl_raw     = '0;
		endcase
		// overflow or clear homes the cursor
		if (ctl_raw.clr) begin
			col_next = '0;
			row_next = '0;
		end
	end

	assign ctl = en ? ctl_raw : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (en) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

endmodule

// ----- hw/rtl/tcw_screen.sv -----
// tcw_screen: screen cell memory, one write and one registered read port,
// with the blanking sweep run after reset and on clear. Depends on tcw_pkg.
module tcw_screen import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mem_ctl_t                        ctl,
	input  logic [$clog2(COLUMNS*ROWS)-1:0] wr_addr,
	input  logic [7:0]                      wr_data,
	input  logic [$clog2(COLUMNS*ROWS)-1:0] rd_addr,
	output logic [7:0]                      rd_data,
	output logic                            busy
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELL_COUNT - 1);

	logic [7:0]        mem [CELL_COUNT];
	logic [7:0]        rd_data_q;
	logic [CELL_W-1:0] sweep_q;
	logic              clearing_q;

	assign rd_data = rd_data_q;
	assign busy    = clearing_q;

	// the sweep owns the write port while it runs
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[sweep_q] <= BLANK_CHAR;
		end else if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			sweep_q    <= '0;
		end else if (ctl.clr) begin
			clearing_q <= 1'b1;
			sweep_q    <= '0;
		end else if (clearing_q) begin
			if (sweep_q == CELL_LAST) clearing_q <= 1'b0;
			else sweep_q <= sweep_q + CELL_W'(1);
		end
	end

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// text_console_writer: character cell console, top level with stream ports.
// Depends on tcw_pkg, tcw_cursor and tcw_screen.
//
// Usage: each word on the s_ group is one command (put, backspace, clear,
// read); each produces exactly one word on the m_ group carrying the read
// character (0 unless read), the cursor after the command and a flag set when
// the command blanked the screen.
// Path: the result word passes through stage 1 and the output register to m_tvalid.
// Throughput: one word per cycle for puts, backspaces and reads while m_tready
// stays high. A clear, or a put that runs past the last row, blanks the screen
// one cell per cycle through the single write port of the screen memory, with
// s_tready low until the sweep ends. Its result word still leaves without waiting for the sweep.
// Reset: the cursor goes home and the same blanking sweep runs over every
// cell, with s_tready low while it runs.
// Stall: a held result sits in the output register; one more word can be
// accepted into the stage behind it, then s_tready drops until m_tready.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, [23:19] zero
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [7:0] cell_char, [14:8] cursor_column,
	                               // [19:15] cursor_row, [20] screen_cleared, [23:21] zero
);

	localparam int CELL_W = $clog2(COLUMNS * ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);

	logic              accept;
	logic              s1_adv;
	logic              busy;
	cmd_t              cmd;
	mem_ctl_t          ctl;
	logic [CELL_W-1:0] wr_addr;
	logic [CELL_W-1:0] rd_addr;
	logic [7:0]        wr_data;
	logic [7:0]        rd_data;
	logic [COL_W-1:0]  col_next;
	logic [ROW_W-1:0]  row_next;

	logic              valid_s1;
	logic              is_rd_s1;
	logic              clr_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W+7:0]  col_wide;
	logic [ROW_W+5:0]  row_wide;

	logic              m_tvalid_q;
	logic [23:0]       m_tdata_q;

	assign cmd      = cmd_t'(s_tuser[1:0]);
	assign s1_adv   = !m_tvalid_q || m_tready;
	assign s_tready = !busy && (!valid_s1 || s1_adv);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	tcw_cursor #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.cmd        (cmd),
		.char_code  (s_tdata[7:0]),
		.cell_index (s_tdata[18:8]),
		.ctl        (ctl),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.col_next   (col_next),
		.row_next   (row_next)
	);

	tcw_screen #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_screen (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.busy    (busy)
	);

	// zero-extend the cursor so the output fields can be sliced from it
	assign col_wide = {8'b0, col_s1};
	assign row_wide = {6'b0, row_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			is_rd_s1   <= 1'b0;
			clr_s1     <= 1'b0;
			col_s1     <= '0;
			row_s1     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				is_rd_s1 <= ctl.rd;
				clr_s1   <= ctl.clr;
				col_s1   <= col_next;
				row_s1   <= row_next;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				m_tvalid_q <= valid_s1;
				if (valid_s1) begin
					m_tdata_q <= {3'b000, clr_s1, row_wide[4:0], col_wide[6:0],
						(is_rd_s1 ? rd_data : 8'h00)};
				end
			end
		end
	end

	a_no_accept_while_sweeping: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready)
		else $error("word accepted during blanking sweep");

	a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_CLEAR) |=> busy)
		else $error("clear did not start the blanking sweep");

	a_cleared_is_home: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[20]) |-> (m_tdata[19:8] == 12'd0))
		else $error("blanked screen reported with cursor away from home");

	a_full_pipe_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("word accepted with both stages held");

endmodule

// ----- tb/sv/tcw_console_check.sv -----
// tcw_console_check: watches both stream groups of the text console writer,
// predicts each result word from its own screen copy and compares. Uses tcw_pkg.
module tcw_console_check import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, [23:19] zero
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [7:0] cell_char, [14:8] cursor_column,
	                               // [19:15] cursor_row, [20] screen_cleared
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic       cleared;
		logic [4:0] row;
		logic [6:0] col;
		logic [7:0] cell_char;
	} console_word_t;

	logic [7:0]    screen [COLUMNS*ROWS];
	int            cur_col;
	int            cur_row;
	console_word_t due_words [$];

	task automatic blank_screen();
		foreach (screen[i]) screen[i] = BLANK_CHAR;
		cur_col = 0;
		cur_row = 0;
	endtask

	// Apply one command to the screen copy and form the word it must produce.
	task automatic console_apply(input cmd_t cmd, input logic [7:0] ch,
		input logic [10:0] idx, output console_word_t res);
		res = '0;
		case (cmd)
			CMD_PUT: begin
				if (ch != NULL_CHAR) begin
					if (ch == NEWLINE_CHAR) begin
						cur_col = 0;
						cur_row++;
					end else begin
						screen[cur_row*COLUMNS + cur_col] = ch;
						cur_col++;
					end
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						cur_row++;
					end
					// no scroll: running off the bottom blanks everything
					if (cur_row >= ROWS) begin
						blank_screen();
						res.cleared = 1'b1;
					end
				end
			end
			CMD_BACK: begin
				if (cur_col > 0) begin
					cur_col--;
					screen[cur_row*COLUMNS + cur_col] = BLANK_CHAR;
				end
			end
			CMD_CLEAR: begin
				blank_screen();
				res.cleared = 1'b1;
			end
			default: begin
				if (idx < COLUMNS*ROWS) res.cell_char = screen[idx];
			end
		endcase
		res.col = cur_col[6:0];
		res.row = cur_row[4:0];
	endtask

	task automatic compare_word(input console_word_t want, input console_word_t got);
		bit bad;
		bad = 0;
		if (got.cell_char !== want.cell_char) begin
			$display("%0t: cell_char expected %0d actual %0d", $time, want.cell_char,
				got.cell_char);
			bad = 1;
		end
		if (got.col !== want.col) begin
			$display("%0t: cursor_column expected %0d actual %0d", $time, want.col, got.col);
			bad = 1;
		end
		if (got.row !== want.row) begin
			$display("%0t: cursor_row expected %0d actual %0d", $time, want.row, got.row);
			bad = 1;
		end
		if (got.cleared !== want.cleared) begin
			$display("%0t: screen_cleared expected %0b actual %0b", $time, want.cleared,
				got.cleared);
			bad = 1;
		end
		if (bad) mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		console_word_t want;
		console_word_t got;
		if (!arst_n) begin
			blank_screen();
			due_words.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			// retire the oldest result before queueing the new one
			if (m_tvalid && m_tready) begin
				got = m_tdata[20:0];
				if (due_words.size() == 0) begin
					$display("%0t: result word expected none actual %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = due_words.pop_front();
					compare_word(want, got);
				end
			end
			if (s_tvalid && s_tready) begin
				console_apply(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[18:8], want);
				due_words.push_back(want);
			end
			pending = due_words.size();
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
// tb: drives command words into text_console_writer with bursty timing and a
// stalling receiver; tcw_console_check does the prediction. Uses tcw_pkg.
module tb;
	import tcw_pkg::*;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int ITEMS      = 1350;
	localparam int IDLE_LIMIT = 12000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = CMD_PUT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	int mismatches;
	int pending;
	int sent       = 0;
	int burst_left = 0;
	int idle_cycles;
	int rx_mode;
	int rx_left;

	text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	tcw_console_check #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver: runs in modes of random length, from always ready to mostly stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode  <= 0;
			rx_left  <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_left <= $urandom_range(10, 150);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	// Stop the run when no word moves on either side for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Send one command word; open a new burst after a random gap when one runs out.
	task automatic issue(input cmd_t cmd, input logic [7:0] ch, input logic [10:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
			                                         : $urandom_range(1, 20);
		end
		burst_left--;
		s_tuser  <= cmd;
		s_tdata  <= {5'b0, idx, ch};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Read address biased toward the top rows, where text tends to sit; some are out of range or corner cells.
	function automatic logic [10:0] pick_cell();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) return 11'($urandom_range(0, COLUMNS*ROWS - 1));
		if (sel < 8) return 11'($urandom_range(0, COLUMNS*8 - 1));
		if (sel < 9) return 11'($urandom_range(COLUMNS*ROWS, 2047));
		case ($urandom_range(0, 3))
			0:       return 11'd0;
			1:       return 11'(COLUMNS - 1);
			2:       return 11'(COLUMNS*(ROWS - 1));
			default: return 11'(COLUMNS*ROWS - 1);
		endcase
	endfunction

	task automatic mixed_text(input int count);
		int sel;
		logic [7:0] ch;
		repeat (count) begin
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				issue(CMD_PUT, 8'($urandom_range(8'h20, 8'h7E)), 11'($urandom_range(0, 2047)));
			end else if (sel < 58) begin
				issue(CMD_PUT, NEWLINE_CHAR, 11'($urandom_range(0, 2047)));
			end else if (sel < 65) begin
				ch = 8'($urandom_range(0, 255));
				issue(CMD_PUT, ch, 11'($urandom_range(0, 2047)));
			end else if (sel < 75) begin
				issue(CMD_BACK, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			end else if (sel < 98) begin
				issue(CMD_READ, 8'($urandom_range(0, 255)), pick_cell());
			end else begin
				issue(CMD_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			end
		end
	endtask

	initial begin
		int kind;
		int run;
		logic [7:0] ch;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: blank screen reads, out of range reads, edge bytes, backspace edges
		issue(CMD_READ, 8'h00, 11'd0);
		issue(CMD_READ, 8'hFF, 11'd1999);
		issue(CMD_READ, 8'h00, 11'd2000);
		issue(CMD_READ, 8'h00, 11'd2047);
		issue(CMD_BACK, 8'h00, 11'd0);
		issue(CMD_PUT, NULL_CHAR, 11'd0);
		issue(CMD_PUT, 8'h41, 11'h7FF);
		issue(CMD_PUT, 8'hFF, 11'd0);
		issue(CMD_PUT, 8'h80, 11'd0);
		issue(CMD_PUT, 8'h01, 11'd0);
		issue(CMD_READ, 8'h00, 11'd0);
		issue(CMD_READ, 8'h00, 11'd3);
		issue(CMD_BACK, 8'h00, 11'd0);
		issue(CMD_READ, 8'h00, 11'd3);
		issue(CMD_PUT, NEWLINE_CHAR, 11'd0);
		issue(CMD_BACK, 8'h00, 11'd0);
		issue(CMD_PUT, 8'h42, 11'd0);
		issue(CMD_READ, 8'h00, 11'(COLUMNS));
		issue(CMD_BACK, 8'h00, 11'd0);
		issue(CMD_READ, 8'h00, 11'(COLUMNS));
		issue(CMD_PUT, 8'h7E, 11'd0);
		issue(CMD_CLEAR, 8'h00, 11'd0);
		issue(CMD_READ, 8'h00, 11'd0);
		issue(CMD_READ, 8'h00, 11'(COLUMNS));

		while (sent < ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				mixed_text($urandom_range(10, 40));
			end else if (kind < 85) begin
				// long line, usually long enough to force column wrap
				run = $urandom_range(70, 170);
				repeat (run) begin
					ch = 8'($urandom_range(1, 255));
					if (ch == NEWLINE_CHAR) ch = 8'h41;
					issue(CMD_PUT, ch, 11'($urandom_range(0, 2047)));
				end
				repeat ($urandom_range(2, 6)) issue(CMD_READ, 8'h00, pick_cell());
			end else if (kind < 95) begin
				// newline run, which can walk off the last row
				repeat ($urandom_range(10, 30)) issue(CMD_PUT, NEWLINE_CHAR, 11'd0);
				issue(CMD_BACK, 8'h00, 11'd0);
			end else begin
				issue(CMD_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
				issue(CMD_READ, 8'h00, pick_cell());
			end
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cursor.sv
hw/rtl/tcw_screen.sv
hw/rtl/text_console_writer.sv
tb/sv/tcw_console_check.sv
tb/sv/tb.sv
